### rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types, widths and codes for the first-fit range allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffra_pkg;

   // table depth and derived index widths
   localparam int MAX_RANGES = 64;
   localparam int IDX_W      = $clog2(MAX_RANGES);
   localparam int CNT_W      = $clog2(MAX_RANGES + 1);

   // field widths
   localparam int ADDR_W  = 32;
   localparam int SIZE_W  = 33;
   localparam int ALIGN_W = 17;
   localparam int STAT_W  = 2;
   localparam int CSR_W   = 33;
   localparam int CSRI_W  = 1;

   // working width of start/end arithmetic (holds begin + length + roundings)
   localparam int VAL_W = 36;
   localparam int BIT_W = $clog2(VAL_W);

   // register reset values
   localparam logic [SIZE_W-1:0]  PAGE_SIZE_RST   = SIZE_W'(268435456);
   localparam logic [ALIGN_W-1:0] GRANULARITY_RST = ALIGN_W'(1024);

   typedef enum logic [CSRI_W-1:0] {
      CSR_PAGE_SIZE   = 1'b0,
      CSR_GRANULARITY = 1'b1
   } csr_idx_type;

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_NO_SPACE  = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // one table entry
   typedef struct packed {
      logic [ADDR_W-1:0] start_addr;
      logic [SIZE_W-1:0] length;
      logic              linear;
   } entry_type;

   typedef enum logic [1:0] {
      RND_END_GRAN,
      RND_START_GRAN,
      RND_START_ALIGN
   } rnd_tgt_type;

   typedef enum logic [1:0] {
      RA_IDX,
      RA_PTR_DN,
      RA_PTR_UP
   } rd_sel_type;

   typedef enum logic {
      WR_SHIFT,
      WR_NEW
   } wr_sel_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_COUNT,
      PTR_IDX,
      PTR_DEC,
      PTR_INC
   } ptr_op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_AL_CHK,
      S_AL_WAIT,
      S_AL_END,
      S_AL_RND_E,
      S_AL_CMP,
      S_AL_NXT,
      S_AL_RND_G,
      S_AL_ALN,
      S_AL_RND_A,
      S_INS_CHK,
      S_INS_WR,
      S_REL_CHK,
      S_REL_WAIT,
      S_DEL_CHK,
      S_DEL_WR,
      S_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic        req_ready;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        set_end;
      logic        set_start;
      logic        rnd_go;
      rnd_tgt_type rnd_tgt;
      logic        idx_inc;
      ptr_op_type  ptr_op;
      logic        wr_en;
      wr_sel_type  wr_sel;
      logic        count_inc;
      logic        count_dec;
      logic        res_set;
      status_type  res_status;
      logic        res_use_start;
      logic        rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_valid;
      logic is_release;
      logic full;
      logic size_zero;
      logic at_count;
      logic differs;
      logic end_fits;
      logic page_ok;
      logic match;
      logic ptr_above;
      logic ptr_last;
      logic rnd_done;
      logic rsp_busy;
   } sts_type;

endpackage

`default_nettype wire

### rtl/ffra_if.sv
// ----------------------------------------------------------------------------
// ffra request / response channels
// Valid/ready channels carrying one request word and one response word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffra_req_if
   import ffra_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [SIZE_W-1:0]  request_size;
   logic [ALIGN_W-1:0] alignment;
   logic               is_linear;
   logic [ADDR_W-1:0]  release_offset;

   modport source (output valid, output operation, output request_size,
                   output alignment, output is_linear, output release_offset,
                   input ready);
   modport sink   (input valid, input operation, input request_size,
                   input alignment, input is_linear, input release_offset,
                   output ready);
endinterface

interface ffra_rsp_if
   import ffra_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [ADDR_W-1:0] granted_offset;

   modport source (output valid, output status, output granted_offset, input ready);
   modport sink   (input valid, input status, input granted_offset, output ready);
endinterface

`default_nettype wire

### rtl/ffra_round.sv
// ----------------------------------------------------------------------------
// ffra_round
// Rounds a value up to a multiple of a 17-bit unit. Power-of-two units finish
// the cycle after go by masking; others run a restoring remainder, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_round
   import ffra_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               go,
   input  wire logic [VAL_W-1:0]   x,
   input  wire logic [ALIGN_W-1:0] unit,
   output logic                    done,
   output logic [VAL_W-1:0]        y
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [VAL_W-1:0]   x_ff, x_in;
   logic [ALIGN_W-1:0] a_ff, a_in;
   logic [ALIGN_W-1:0] rem_ff, rem_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;

   logic [ALIGN_W-1:0] a_eff;
   logic               pow2;
   logic [ALIGN_W:0]   trial;
   logic [ALIGN_W:0]   trial_sub;

   // a zero unit counts as one
   assign a_eff     = (unit == '0) ? ALIGN_W'(1) : unit;
   assign pow2      = ((a_eff & (a_eff - ALIGN_W'(1))) == '0);
   assign trial     = {rem_ff, x_ff[bit_ff]};
   assign trial_sub = trial - {1'b0, a_ff};

   // next-state of the remainder engine
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      a_in    = a_ff;
      rem_in  = rem_ff;
      bit_in  = bit_ff;
      if (go) begin
         x_in = x;
         a_in = a_eff;
         if (pow2) begin
            rem_in  = x[ALIGN_W-1:0] & (a_eff - ALIGN_W'(1));
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            rem_in  = '0;
            bit_in  = BIT_W'(VAL_W - 1);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, a_ff}) ? trial_sub[ALIGN_W-1:0] : trial[ALIGN_W-1:0];
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - BIT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      a_ff   <= a_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
   end

   // round up: add what the remainder is short of a full unit
   assign done = done_ff;
   assign y    = (rem_ff == '0) ? x_ff : x_ff + VAL_W'(a_ff - rem_ff);

endmodule

`default_nettype wire

### rtl/ffra_datapath.sv
// ----------------------------------------------------------------------------
// ffra_datapath
// Range table memory, scan registers, config registers and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_datapath
   import ffra_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   ffra_req_if.sink               req_bus,
   ffra_rsp_if.source             rsp_bus,
   input  wire logic              csr_write_enable,
   input  wire logic [CSRI_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]  csr_write_data,
   input  wire cmd_type           cmd,
   output sts_type                sts
);

   entry_type mem [MAX_RANGES];

   logic [SIZE_W-1:0]  page_size_ff;
   logic [ALIGN_W-1:0] gran_ff;

   logic               op_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [ALIGN_W-1:0] align_ff;
   logic               lin_ff;
   logic [ADDR_W-1:0]  roff_ff;

   logic [VAL_W-1:0]   start_ff;
   logic [VAL_W-1:0]   end_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   count_ff;
   entry_type          rd_ff;
   rnd_tgt_type        tgt_ff;

   status_type         res_status_ff;
   logic [ADDR_W-1:0]  res_offset_ff;
   logic               rsp_valid_ff;
   logic [STAT_W-1:0]  rsp_status_ff;
   logic [ADDR_W-1:0]  rsp_offset_ff;

   logic               accept;
   logic [CNT_W-1:0]   ptr_dn, ptr_up;
   logic [IDX_W-1:0]   rd_addr, wr_addr;
   entry_type          wr_data;
   logic [VAL_W-1:0]   size_ext, start_plus;
   logic [VAL_W-1:0]   rnd_x, rnd_y;
   logic [ALIGN_W-1:0] rnd_unit;
   logic               rnd_done;
   logic [CNT_W:0]     ptr_next;

   assign accept   = req_bus.valid && cmd.req_ready;
   assign ptr_dn   = ptr_ff - CNT_W'(1);
   assign ptr_up   = ptr_ff + CNT_W'(1);
   assign ptr_next = {1'b0, ptr_ff} + (CNT_W+1)'(1);
   assign size_ext = VAL_W'(size_ff);
   assign start_plus = start_ff + size_ext;

   // rounding operand select
   always_comb begin
      unique case (cmd.rnd_tgt)
         RND_END_GRAN:    begin rnd_x = end_ff;   rnd_unit = gran_ff;  end
         RND_START_GRAN:  begin rnd_x = start_ff; rnd_unit = gran_ff;  end
         RND_START_ALIGN: begin rnd_x = start_ff; rnd_unit = align_ff; end
         default:         begin rnd_x = start_ff; rnd_unit = align_ff; end
      endcase
   end

   ffra_round u_round (
      .clock (clock),
      .reset (reset),
      .go    (cmd.rnd_go),
      .x     (rnd_x),
      .unit  (rnd_unit),
      .done  (rnd_done),
      .y     (rnd_y)
   );

   // memory addressing
   always_comb begin
      unique case (cmd.rd_sel)
         RA_IDX:    rd_addr = idx_ff[IDX_W-1:0];
         RA_PTR_DN: rd_addr = ptr_dn[IDX_W-1:0];
         RA_PTR_UP: rd_addr = ptr_up[IDX_W-1:0];
         default:   rd_addr = idx_ff[IDX_W-1:0];
      endcase
      if (cmd.wr_sel == WR_NEW) begin
         wr_addr            = idx_ff[IDX_W-1:0];
         wr_data.start_addr = start_ff[ADDR_W-1:0];
         wr_data.length     = size_ff;
         wr_data.linear     = lin_ff;
      end else begin
         wr_addr = ptr_ff[IDX_W-1:0];
         wr_data = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // pointer for shifting entries
   always_comb begin
      unique case (cmd.ptr_op)
         PTR_HOLD:  ptr_in = ptr_ff;
         PTR_COUNT: ptr_in = count_ff;
         PTR_IDX:   ptr_in = idx_ff;
         PTR_DEC:   ptr_in = ptr_dn;
         PTR_INC:   ptr_in = ptr_up;
         default:   ptr_in = ptr_ff;
      endcase
   end

   // request word, scan registers and result
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_bus.operation;
         size_ff  <= req_bus.request_size;
         align_ff <= req_bus.alignment;
         lin_ff   <= req_bus.is_linear;
         roff_ff  <= req_bus.release_offset;
         start_ff <= '0;
         idx_ff   <= '0;
      end else begin
         if (cmd.idx_inc) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
         if (cmd.set_start) begin
            start_ff <= VAL_W'(rd_ff.start_addr) + VAL_W'(rd_ff.length);
         end else if (rnd_done && tgt_ff != RND_END_GRAN) begin
            start_ff <= rnd_y;
         end
      end
      if (cmd.set_end) begin
         end_ff <= start_plus;
      end else if (rnd_done && tgt_ff == RND_END_GRAN) begin
         end_ff <= rnd_y;
      end
      if (cmd.rnd_go) begin
         tgt_ff <= cmd.rnd_tgt;
      end
      ptr_ff <= ptr_in;
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         res_offset_ff <= cmd.res_use_start ? start_ff[ADDR_W-1:0] : '0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_offset_ff <= res_offset_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff <= PAGE_SIZE_RST;
         gran_ff      <= GRANULARITY_RST;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_idx_type'(csr_index))
               CSR_PAGE_SIZE:   page_size_ff <= csr_write_data[SIZE_W-1:0];
               CSR_GRANULARITY: gran_ff      <= csr_write_data[ALIGN_W-1:0];
               default:         page_size_ff <= page_size_ff;
            endcase
         end
         if (cmd.count_inc) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.count_dec) begin
            count_ff <= count_ff - CNT_W'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // status to the controller
   always_comb begin
      sts.req_valid  = req_bus.valid;
      sts.is_release = (op_type'(op_ff) == OP_RELEASE);
      sts.full       = (count_ff >= CNT_W'(MAX_RANGES));
      sts.size_zero  = (size_ff == '0);
      sts.at_count   = (idx_ff == count_ff);
      sts.differs    = (rd_ff.linear != lin_ff);
      sts.end_fits   = (end_ff <= VAL_W'(rd_ff.start_addr));
      sts.page_ok    = (start_plus <= VAL_W'(page_size_ff));
      sts.match      = (rd_ff.start_addr == roff_ff);
      sts.ptr_above  = (ptr_ff > idx_ff);
      sts.ptr_last   = (ptr_next >= {1'b0, count_ff});
      sts.rnd_done   = rnd_done;
      sts.rsp_busy   = rsp_valid_ff && !rsp_bus.ready;
   end

   assign req_bus.ready          = cmd.req_ready;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.granted_offset = rsp_offset_ff;

endmodule

`default_nettype wire

### rtl/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer: gap scan, insert shift, release search and delete shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_ctrl
   import ffra_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (sts.req_valid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            priority if (sts.is_release) state_in = S_REL_CHK;
            else if (sts.full || sts.size_zero) state_in = S_FINISH;
            else state_in = S_AL_CHK;
         end
         S_AL_CHK: begin
            priority if (!sts.at_count) state_in = S_AL_WAIT;
            else if (sts.page_ok) state_in = S_INS_CHK;
            else state_in = S_FINISH;
         end
         S_AL_WAIT:  state_in = S_AL_END;
         S_AL_END:   state_in = sts.differs ? S_AL_RND_E : S_AL_CMP;
         S_AL_RND_E: if (sts.rnd_done) state_in = S_AL_CMP;
         S_AL_CMP: begin
            priority if (!sts.end_fits) state_in = S_AL_NXT;
            else if (sts.page_ok) state_in = S_INS_CHK;
            else state_in = S_FINISH;
         end
         S_AL_NXT:   state_in = sts.differs ? S_AL_RND_G : S_AL_RND_A;
         S_AL_RND_G: if (sts.rnd_done) state_in = S_AL_ALN;
         S_AL_ALN:   state_in = S_AL_RND_A;
         S_AL_RND_A: if (sts.rnd_done) state_in = S_AL_CHK;
         S_INS_CHK:  state_in = sts.ptr_above ? S_INS_WR : S_FINISH;
         S_INS_WR:   state_in = S_INS_CHK;
         S_REL_CHK:  state_in = sts.at_count ? S_FINISH : S_REL_WAIT;
         S_REL_WAIT: state_in = sts.match ? S_DEL_CHK : S_REL_CHK;
         S_DEL_CHK:  state_in = sts.ptr_last ? S_FINISH : S_DEL_WR;
         S_DEL_WR:   state_in = S_DEL_CHK;
         S_FINISH:   if (!sts.rsp_busy) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      cmd.rd_sel     = RA_IDX;
      cmd.rnd_tgt    = RND_START_ALIGN;
      cmd.ptr_op     = PTR_HOLD;
      cmd.wr_sel     = WR_SHIFT;
      cmd.res_status = ST_OK;
      unique case (state_ff)
         S_IDLE: cmd.req_ready = 1'b1;
         S_DISPATCH: begin
            if (!sts.is_release) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = sts.full ? ST_FULL : ST_NO_SPACE;
            end
         end
         S_AL_CHK: begin
            if (!sts.at_count) begin
               cmd.rd_en = 1'b1;
            end else begin
               cmd.res_set       = 1'b1;
               cmd.res_status    = sts.page_ok ? ST_OK : ST_NO_SPACE;
               cmd.res_use_start = sts.page_ok;
               cmd.ptr_op        = PTR_COUNT;
            end
         end
         S_AL_WAIT: cmd.set_end = 1'b1;
         S_AL_END: begin
            cmd.rnd_go  = sts.differs;
            cmd.rnd_tgt = RND_END_GRAN;
         end
         S_AL_RND_E: cmd.rnd_tgt = RND_END_GRAN;
         S_AL_CMP: begin
            if (!sts.end_fits) begin
               cmd.set_start = 1'b1;
            end else begin
               cmd.res_set       = 1'b1;
               cmd.res_status    = sts.page_ok ? ST_OK : ST_NO_SPACE;
               cmd.res_use_start = sts.page_ok;
               cmd.ptr_op        = PTR_COUNT;
            end
         end
         S_AL_NXT: begin
            cmd.rnd_go  = 1'b1;
            cmd.rnd_tgt = sts.differs ? RND_START_GRAN : RND_START_ALIGN;
         end
         S_AL_RND_G: cmd.rnd_tgt = RND_START_GRAN;
         S_AL_ALN:   cmd.rnd_go  = 1'b1;
         S_AL_RND_A: cmd.idx_inc = sts.rnd_done;
         S_INS_CHK: begin
            if (sts.ptr_above) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_PTR_DN;
            end else begin
               cmd.wr_en     = 1'b1;
               cmd.wr_sel    = WR_NEW;
               cmd.count_inc = 1'b1;
            end
         end
         S_INS_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.ptr_op = PTR_DEC;
         end
         S_REL_CHK: begin
            if (sts.at_count) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_NOT_FOUND;
            end else begin
               cmd.rd_en = 1'b1;
            end
         end
         S_REL_WAIT: begin
            if (sts.match) begin
               cmd.res_set = 1'b1;
               cmd.ptr_op  = PTR_IDX;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_DEL_CHK: begin
            if (sts.ptr_last) begin
               cmd.count_dec = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_PTR_UP;
            end
         end
         S_DEL_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.ptr_op = PTR_INC;
         end
         S_FINISH: cmd.rsp_load = !sts.rsp_busy;
         default: cmd.req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/first_fit_range_allocator.sv
// An allocate scans the table entry by entry (with extra rounding where the
// linear flags differ) and then shifts later entries up on insert; each rounding
// by a non-power-of-two unit runs a bit-serial remainder. A release searches
// entry by entry and then shifts later entries down.
// Only one request word is in flight at a time, set by the table scan and shift.
// Reset (synchronous): table empty, page size 268435456, granularity 1024.
// ----------------------------------------------------------------------------
// first_fit_range_allocator
// First-fit allocator of ranges in one memory page, sorted by start offset.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_range_allocator
   import ffra_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   ffra_req_if.sink               req_bus,
   ffra_rsp_if.source             rsp_bus,
   input  wire logic              csr_write_enable,
   input  wire logic [CSRI_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]  csr_write_data
);

   cmd_type cmd;
   sts_type sts;

   ffra_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   ffra_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

`default_nettype wire

### rtl/ffra_checker.sv
// ----------------------------------------------------------------------------
// ffra_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_checker
   import ffra_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [STAT_W-1:0] rsp_status,
   input wire logic [ADDR_W-1:0] rsp_offset
);

   // a held response word keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_offset))
      else $error("response word changed while stalled");

   // one word in flight: the block is busy right after taking one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while busy");

   // failed requests grant no offset
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_offset == '0)
      else $error("nonzero offset on failed request");

   // no response word right out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind first_fit_range_allocator ffra_checker u_ffra_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_status (rsp_bus.status),
   .rsp_offset (rsp_bus.granted_offset)
);

`default_nettype wire
